FILE: rtl/core/slcdw_pkg.sv
package slcdw_pkg;

	localparam int DIGIT_COUNT_DEF = 4;
	localparam int VALUE_W         = 14;
	localparam int FRAME_W         = 13;
	localparam int BIT_CNT_W       = 4;
	localparam int ADDR_W          = 6;

	localparam logic [BIT_CNT_W-1:0] CMD_LEN  = BIT_CNT_W'(12);
	localparam logic [BIT_CNT_W-1:0] DATA_LEN = BIT_CNT_W'(13);
	localparam logic [BIT_CNT_W-1:0] CONV_LEN = BIT_CNT_W'(VALUE_W);

	localparam logic [3:0] CMD_PREFIX  = 4'b1000;
	localparam logic [2:0] DATA_PREFIX = 3'b101;
	localparam logic [7:0] DOT_BIT     = 8'h10;

	typedef enum logic [1:0] {
		OP_CMD    = 2'd0,
		OP_NIBBLE = 2'd1,
		OP_SHOW   = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	function automatic int unsigned pow10(input int n);
		int unsigned p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// seven-segment code, digit taken modulo ten
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0, 4'd10: c = 8'hEB;
			4'd1, 4'd11: c = 8'h0A;
			4'd2, 4'd12: c = 8'hAD;
			4'd3, 4'd13: c = 8'h8F;
			4'd4, 4'd14: c = 8'h4E;
			4'd5, 4'd15: c = 8'hC7;
			4'd6:        c = 8'hE7;
			4'd7:        c = 8'h8A;
			4'd8:        c = 8'hEF;
			4'd9:        c = 8'hCF;
			default:     c = 8'hEB;
		endcase
		return c;
	endfunction

	function automatic logic [FRAME_W-1:0] data_frame(input logic [ADDR_W-1:0] addr,
		input logic [3:0] nib);
		return {DATA_PREFIX, addr, nib};
	endfunction

endpackage

FILE: rtl/core/segment_lcd_serial_writer.sv
// Serial writer for a three-wire segment LCD controller.
// Input channel s_*: one word per command. s_tuser carries the op code:
// command frame, nibble write, show digit position, set value.
// Output channel m_*: one word per serial bit, most significant first.
// m_tlast marks the last bit of a frame (chip select rises after it);
// m_tuser marks the last bit caused by the input word.
// A command frame gives 12 bits, a nibble write 13, a digit show 26
// (two data frames at addresses 2p and 2p+1). Set value gives no output.
// Frames leave a shift register one bit per cycle while the receiver does
// not stall. Set value converts the clamped binary value to decimal one
// bit per cycle (shift and add-three); no word is accepted meanwhile.
// One word is processed at a time: s_tready is high only while idle.
// When the receiver stalls, the output register holds its bit and the
// shifter waits. Reset clears the digit store to zeros and empties the
// output register; after accept, the first bit of a word moves from the
// shift register into the output register once that register is free.
module segment_lcd_serial_writer #(
	parameter int DIGIT_COUNT = slcdw_pkg::DIGIT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // cmd_byte[7:0], address[13:8], nibble[17:14],
	                              // position[19:18], dot[20], value[34:21], zero
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // data_bit[0], zero
	output logic        m_tlast,  // frame_last
	output logic        m_tuser   // frame_last_of_item
);

	localparam int unsigned LIMIT = slcdw_pkg::pow10(DIGIT_COUNT) - 1;
	localparam int unsigned VAL_ALL = (1 << slcdw_pkg::VALUE_W) - 1;
	localparam logic [slcdw_pkg::VALUE_W-1:0] VAL_MAX =
		(LIMIT > VAL_ALL) ? '1 : LIMIT[slcdw_pkg::VALUE_W-1:0];

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t state_q;
	logic [3:0] digit_q [DIGIT_COUNT];
	logic [3:0] digit_adj [DIGIT_COUNT];
	logic [3:0] digit_nxt [DIGIT_COUNT];
	logic [slcdw_pkg::VALUE_W-1:0] bin_q;
	logic [slcdw_pkg::FRAME_W-1:0] shift_q;
	logic [slcdw_pkg::FRAME_W-1:0] pend_q;
	logic pend_vld_q;
	logic [slcdw_pkg::BIT_CNT_W-1:0] cnt_q;
	logic out_vld_q;
	logic out_bit_q;
	logic out_last_q;
	logic out_item_q;

	logic [7:0] cmd_byte;
	logic [5:0] address;
	logic [3:0] nibble;
	logic [1:0] position;
	logic dot;
	logic [slcdw_pkg::VALUE_W-1:0] value;
	logic [slcdw_pkg::VALUE_W-1:0] value_clamp;
	logic in_acc;
	logic out_free;
	logic pos_ok;
	logic [3:0] sel_digit;
	logic [7:0] code;
	logic [slcdw_pkg::ADDR_W-1:0] addr_hi;
	logic [slcdw_pkg::ADDR_W-1:0] addr_lo;
	logic send_step;

	assign cmd_byte = s_tdata[7:0];
	assign address  = s_tdata[13:8];
	assign nibble   = s_tdata[17:14];
	assign position = s_tdata[19:18];
	assign dot      = s_tdata[20];
	assign value    = s_tdata[34:21];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;
	assign send_step = (state_q == ST_SEND) && out_free;

	assign value_clamp = (value > VAL_MAX) ? VAL_MAX : value;
	assign pos_ok      = (int'(position) < DIGIT_COUNT);

	always_comb begin
		sel_digit = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (int'(position) == i) begin
				sel_digit = digit_q[i];
			end
		end
	end

	assign code    = slcdw_pkg::seg_code(sel_digit) | (dot ? slcdw_pkg::DOT_BIT : 8'h00);
	assign addr_hi = {3'b000, position, 1'b0};
	assign addr_lo = {3'b000, position, 1'b1};

	// shift and add-three, one binary bit per cycle
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			digit_adj[i] = (digit_q[i] >= 4'd5) ? digit_q[i] + 4'd3 : digit_q[i];
		end
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (i == DIGIT_COUNT - 1) begin
				digit_nxt[i] = {digit_adj[i][2:0], bin_q[slcdw_pkg::VALUE_W-1]};
			end else begin
				digit_nxt[i] = {digit_adj[i][2:0], digit_adj[i+1][3]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
			cnt_q      <= '0;
			out_vld_q  <= 1'b0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_q[i] <= '0;
			end
		end else begin
			if (send_step) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (slcdw_pkg::op_t'(s_tuser))
							slcdw_pkg::OP_CMD: begin
								cnt_q      <= slcdw_pkg::CMD_LEN;
								pend_vld_q <= 1'b0;
								state_q    <= ST_SEND;
							end
							slcdw_pkg::OP_NIBBLE: begin
								cnt_q      <= slcdw_pkg::DATA_LEN;
								pend_vld_q <= 1'b0;
								state_q    <= ST_SEND;
							end
							slcdw_pkg::OP_SHOW: begin
								if (pos_ok) begin
									cnt_q      <= slcdw_pkg::DATA_LEN;
									pend_vld_q <= 1'b1;
									state_q    <= ST_SEND;
								end
							end
							slcdw_pkg::OP_SET: begin
								cnt_q   <= slcdw_pkg::CONV_LEN;
								state_q <= ST_CONV;
								for (int i = 0; i < DIGIT_COUNT; i++) begin
									digit_q[i] <= '0;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CONV: begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						digit_q[i] <= digit_nxt[i];
					end
					cnt_q <= cnt_q - slcdw_pkg::BIT_CNT_W'(1);
					if (cnt_q == slcdw_pkg::BIT_CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEND: begin
					if (out_free) begin
						if (cnt_q == slcdw_pkg::BIT_CNT_W'(1)) begin
							if (pend_vld_q) begin
								pend_vld_q <= 1'b0;
								cnt_q      <= slcdw_pkg::DATA_LEN;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							cnt_q <= cnt_q - slcdw_pkg::BIT_CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bin_q <= value_clamp;
			case (slcdw_pkg::op_t'(s_tuser))
				slcdw_pkg::OP_CMD:    shift_q <= {slcdw_pkg::CMD_PREFIX, cmd_byte, 1'b0};
				slcdw_pkg::OP_NIBBLE: shift_q <= slcdw_pkg::data_frame(address, nibble);
				slcdw_pkg::OP_SHOW:   shift_q <= slcdw_pkg::data_frame(addr_hi, code[7:4]);
				default:              shift_q <= shift_q;
			endcase
			pend_q <= slcdw_pkg::data_frame(addr_lo, code[3:0]);
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[slcdw_pkg::VALUE_W-2:0], 1'b0};
		end else if (send_step) begin
			if (cnt_q == slcdw_pkg::BIT_CNT_W'(1)) begin
				shift_q <= pend_q;
			end else begin
				shift_q <= {shift_q[slcdw_pkg::FRAME_W-2:0], 1'b0};
			end
		end
		if (send_step) begin
			out_bit_q  <= shift_q[slcdw_pkg::FRAME_W-1];
			out_last_q <= (cnt_q == slcdw_pkg::BIT_CNT_W'(1));
			out_item_q <= (cnt_q == slcdw_pkg::BIT_CNT_W'(1)) && !pend_vld_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0000000, out_bit_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_item_q;

`ifndef SYNTH
	a_item_end_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("item end outside frame end");

	a_show_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == slcdw_pkg::OP_SHOW) && pos_ok |=> !s_tready)
		else $error("digit show accepted without sending");

	a_pend_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q == ST_SEND))
		else $error("second frame pending outside send");
`endif

endmodule

FILE: bench/segment_lcd_serial_writer_test.sv
module segment_lcd_serial_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGITS       = slcdw_pkg::DIGIT_COUNT_DEF;
	localparam int RANDOM_WORDS = 180;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [7:0] SEGMENTS [10] = '{
		8'hEB, 8'h0A, 8'hAD, 8'h8F, 8'h4E, 8'hC7, 8'hE7, 8'h8A, 8'hEF, 8'hCF
	};

	typedef struct packed {
		logic data_bit;
		logic frame_last;
		logic item_last;
	} serial_bit_t;

	class lcd_bit_scoreboard;
		serial_bit_t expected_bits[$];
		logic [3:0] digits [DIGITS];
		int unsigned value_limit;
		int errors;
		int bits_checked;
		int op_count [4];

		function new();
			value_limit = 1;
			for (int i = 0; i < DIGITS; i++) begin
				value_limit = value_limit * 10;
				digits[i] = 4'd0;
			end
			value_limit = value_limit - 1;
			errors = 0;
			bits_checked = 0;
			foreach (op_count[i]) op_count[i] = 0;
		endfunction

		function void queue_frame(logic [12:0] pattern, int len);
			serial_bit_t b;
			for (int i = len - 1; i >= 0; i--) begin
				b.data_bit   = pattern[i];
				b.frame_last = (i == 0);
				b.item_last  = 1'b0;
				expected_bits.push_back(b);
			end
		endfunction

		function void take_word(slcdw_pkg::op_t op, logic [39:0] word);
			int unsigned v;
			int first;
			logic [7:0] code;
			logic [5:0] addr;
			first = expected_bits.size();
			op_count[op]++;
			case (op)
				slcdw_pkg::OP_CMD:
					queue_frame({1'b0, slcdw_pkg::CMD_PREFIX, word[7:0]}, 12);
				slcdw_pkg::OP_NIBBLE:
					queue_frame({slcdw_pkg::DATA_PREFIX, word[13:8], word[17:14]}, 13);
				slcdw_pkg::OP_SHOW: begin
					if (word[19:18] < DIGITS) begin
						addr = {3'b000, word[19:18], 1'b0};
						code = SEGMENTS[digits[word[19:18]] % 10];
						if (word[20])
							code = code | slcdw_pkg::DOT_BIT;
						queue_frame({slcdw_pkg::DATA_PREFIX, addr, code[7:4]}, 13);
						queue_frame({slcdw_pkg::DATA_PREFIX, addr | 6'd1, code[3:0]}, 13);
					end
				end
				slcdw_pkg::OP_SET: begin
					v = {18'd0, word[34:21]};
					if (v > value_limit)
						v = value_limit;
					for (int i = DIGITS - 1; i >= 0; i--) begin
						digits[i] = 4'(v % 10);
						v = v / 10;
					end
				end
				default: ;
			endcase
			if (expected_bits.size() > first)
				expected_bits[expected_bits.size() - 1].item_last = 1'b1;
		endfunction

		function void mismatch(string what, int unsigned exp_v, int unsigned act_v);
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
		endfunction

		function void check_bit(logic [7:0] tdata, logic tlast, logic tuser);
			serial_bit_t b;
			bits_checked++;
			if (expected_bits.size() == 0) begin
				errors++;
				$display("%0t: unexpected bit, expected none got data %0h last %0b item %0b",
					$time, tdata, tlast, tuser);
				return;
			end
			b = expected_bits.pop_front();
			if (tdata !== {7'b0, b.data_bit})
				mismatch("data", 32'({7'b0, b.data_bit}), 32'(tdata));
			if (tlast !== b.frame_last)
				mismatch("frame last", 32'(b.frame_last), 32'(tlast));
			if (tuser !== b.item_last)
				mismatch("item last", 32'(b.item_last), 32'(tuser));
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	lcd_bit_scoreboard sb = new();
	int burst_left = 0;

	segment_lcd_serial_writer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_bit(m_tdata, m_tlast, m_tuser);
	end

	function automatic logic [39:0] pack_word(logic [7:0] cmd, logic [5:0] addr,
		logic [3:0] nib, logic [1:0] pos, logic dot, logic [13:0] value);
		return {5'b0, value, dot, pos, nib, addr, cmd};
	endfunction

	function automatic logic [13:0] random_value();
		case ($urandom_range(0, 9))
			0, 1: return 14'($urandom_range(10000, 16383));
			2: return 14'($urandom_range(9990, 10010));
			default: return 14'($urandom_range(0, 9999));
		endcase
	endfunction

	function automatic logic [39:0] random_word();
		return pack_word(8'($urandom), 6'($urandom), 4'($urandom), 2'($urandom),
			1'($urandom), random_value());
	endfunction

	task automatic send_word(slcdw_pkg::op_t op, logic [39:0] word);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		sb.take_word(op, word);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= 40'({$urandom, $urandom});
				s_tuser  <= 2'($urandom);
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end
		end
	endtask

	task automatic show_digit(logic [1:0] pos, logic dot);
		send_word(slcdw_pkg::OP_SHOW, pack_word(8'($urandom), 6'($urandom), 4'($urandom),
			pos, dot, 14'($urandom)));
	endtask

	task automatic set_value(logic [13:0] value);
		send_word(slcdw_pkg::OP_SET, pack_word(8'($urandom), 6'($urandom), 4'($urandom),
			2'($urandom), 1'($urandom), value));
	endtask

	initial begin
		bit held;
		int mode;
		int span;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.bits_checked >= 1200) begin
				held = 1'b1;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 40);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom);
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	initial begin
		int waited;
		int pick;
		logic [39:0] word;
		waited = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		show_digit(2'd0, 1'b0);
		show_digit(2'd3, 1'b1);
		send_word(slcdw_pkg::OP_CMD, pack_word(8'h00, 6'h3F, 4'hF, 2'd3, 1'b1, 14'h3FFF));
		send_word(slcdw_pkg::OP_CMD, pack_word(8'hFF, 6'h00, 4'h0, 2'd0, 1'b0, 14'h0000));
		send_word(slcdw_pkg::OP_NIBBLE, pack_word(8'hFF, 6'h00, 4'h0, 2'd3, 1'b1, 14'h3FFF));
		send_word(slcdw_pkg::OP_NIBBLE, pack_word(8'h00, 6'h3F, 4'hF, 2'd0, 1'b0, 14'h0000));
		set_value(14'd1234);
		for (int p = 0; p < 4; p++)
			show_digit(2'(p), 1'(p));
		set_value(14'd5678);
		for (int p = 0; p < 4; p++)
			show_digit(2'(p), ~1'(p));
		set_value(14'd16383);
		show_digit(2'd0, 1'b0);
		show_digit(2'd3, 1'b1);
		set_value(14'd10000);
		show_digit(2'd1, 1'b0);
		set_value(14'd0);
		show_digit(2'd2, 1'b1);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			word = random_word();
			pick = $urandom_range(0, 19);
			if (pick < 4)
				send_word(slcdw_pkg::OP_CMD, word);
			else if (pick < 8)
				send_word(slcdw_pkg::OP_NIBBLE, word);
			else if (pick < 15)
				send_word(slcdw_pkg::OP_SHOW, word);
			else
				send_word(slcdw_pkg::OP_SET, word);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_bits.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.expected_bits.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected bits never arrived", $time, sb.expected_bits.size());
		end

		$display("Sent %0d command, %0d nibble, %0d show and %0d set words; %0d bits checked",
			sb.op_count[slcdw_pkg::OP_CMD], sb.op_count[slcdw_pkg::OP_NIBBLE],
			sb.op_count[slcdw_pkg::OP_SHOW], sb.op_count[slcdw_pkg::OP_SET],
			sb.bits_checked);
		$display("Random input gaps, output stalls and one %0d-cycle output hold-off applied",
			HOLD_CYCLES);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/slcdw_pkg.sv
rtl/core/segment_lcd_serial_writer.sv
bench/segment_lcd_serial_writer_test.sv
